[src/key_mode_priority_controller_top_assert.svh]
// Assertion macros shared by the controller's RTL files.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef KEY_MODE_PRIORITY_CONTROLLER_TOP_ASSERT_SVH
`define KEY_MODE_PRIORITY_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KMPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kmpc_pkg.sv]
package kmpc_pkg;

  // Mode and priority codes.
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_NORMAL = 3'd1;
  localparam logic [2:0] MODE_SOS    = 3'd2;
  localparam logic [2:0] MODE_MOVE   = 3'd3;
  localparam logic [2:0] MODE_PULL   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [1:0] CFG_ESCALATE   = 2'd1;
  localparam logic [1:0] CFG_RETURN     = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] LONG_PRESS_RESET = 16'd200;
  localparam logic [7:0]  ESCALATE_RESET   = 8'd3;
  localparam logic [7:0]  RETURN_RESET     = 8'd20;

  localparam logic [15:0] PRESS_MAX  = 16'hFFFF;
  localparam logic [7:0]  SETTLE_MAX = 8'hFF;

  typedef struct packed {
    logic        power_on;
    logic [15:0] press_count;
    logic        key_locked;
    logic [2:0]  mode;
    logic [7:0]  settle_count;
    logic [2:0]  last_priority;
  } state_t;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [7:0]  escalate_ticks;
    logic [7:0]  return_ticks;
  } config_t;

  typedef struct packed {
    logic       action;
    logic       power_key;
    logic       sos_key;
    logic       move_key;
    logic       pull_key;
  } keys_t;

  typedef struct packed {
    logic       power_started;
    logic [2:0] mode_started;
  } events_t;

endpackage

[src/key_mode_priority_controller_top.sv]
// Key-driven power latch and mode priority controller. One input transaction
// (a fast or a slow tick with four key levels) is taken per clock cycle while
// the input side is ready, and yields exactly one result transaction in the
// next cycle, held in the single result register. The input side stalls only while a result
// waits in that register and the output side is not ready. Configuration
// writes are always accepted and should only be issued while no result is
// pending. Writes to index 3 are accepted and ignored.
`include "key_mode_priority_controller_top_assert.svh"

module key_mode_priority_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic        power_key_i,
  input  logic        sos_key_i,
  input  logic        move_key_i,
  input  logic        pull_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        powered_o,
  output logic        power_started_o,
  output logic [2:0]  mode_o,
  output logic [2:0]  mode_started_o,
  output logic        alarm_led_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  kmpc_pkg::state_t  state_q, state_d;
  kmpc_pkg::config_t cfg_q;
  kmpc_pkg::keys_t   keys;
  kmpc_pkg::events_t events_d, events_q;
  logic              out_valid_q;
  logic              in_fire;

  assign keys = '{action:    action_i,
                  power_key: power_key_i,
                  sos_key:   sos_key_i,
                  move_key:  move_key_i,
                  pull_key:  pull_key_i};

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  kmpc_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .keys_i   (keys),
    .state_o  (state_d),
    .events_o (events_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= kmpc_pkg::LONG_PRESS_RESET;
      cfg_q.escalate_ticks   <= kmpc_pkg::ESCALATE_RESET;
      cfg_q.return_ticks     <= kmpc_pkg::RETURN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kmpc_pkg::CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        kmpc_pkg::CFG_ESCALATE:   cfg_q.escalate_ticks   <= cfg_data_i[7:0];
        kmpc_pkg::CFG_RETURN:     cfg_q.return_ticks     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Result payload; the state register itself carries powered and mode.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      events_q <= events_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign powered_o       = state_q.power_on;
  assign power_started_o = events_q.power_started;
  assign mode_o          = state_q.mode;
  assign mode_started_o  = events_q.mode_started;
  assign alarm_led_o     = (state_q.mode == kmpc_pkg::MODE_SOS) ||
                           (state_q.mode == kmpc_pkg::MODE_PULL);

  `KMPC_ASSERT_NEXT(a_power_sticks, state_q.power_on, state_q.power_on, "power turned off")
  `KMPC_ASSERT_NEXT(a_result_follows, in_fire, out_valid_q, "accepted tick gave no result")
  `KMPC_ASSERT_NOW(a_start_matches_mode, out_valid_q && mode_started_o != kmpc_pkg::MODE_NONE,
                   mode_started_o == mode_o, "started mode differs from current mode")
  `KMPC_ASSERT_NOW(a_power_start_clean, out_valid_q && power_started_o,
                   powered_o && mode_o == kmpc_pkg::MODE_NONE &&
                   mode_started_o == kmpc_pkg::MODE_NONE,
                   "power start with stale mode")
  `KMPC_ASSERT_NOW(a_mode_range, 1'b1, state_q.mode <= kmpc_pkg::MODE_PULL, "mode out of range")

endmodule

[src/kmpc_step.sv]
module kmpc_step (
  input  kmpc_pkg::state_t  state_i,
  input  kmpc_pkg::config_t cfg_i,
  input  kmpc_pkg::keys_t   keys_i,
  output kmpc_pkg::state_t  state_o,
  output kmpc_pkg::events_t events_o
);

  logic [2:0] priority_sel;
  logic       allowed;
  logic [7:0] threshold;
  logic       press_fire;
  logic       settle_fire;

  always_comb begin
    priority_sel = kmpc_pkg::MODE_NORMAL;
    if (keys_i.sos_key)  priority_sel = kmpc_pkg::MODE_SOS;
    if (keys_i.move_key) priority_sel = kmpc_pkg::MODE_MOVE;
    if (keys_i.pull_key) priority_sel = kmpc_pkg::MODE_PULL;
  end

  // Which transition a steady priority may take from the current mode.
  always_comb begin
    allowed   = 1'b0;
    threshold = cfg_i.escalate_ticks;
    if (state_i.mode == kmpc_pkg::MODE_NONE) begin
      allowed = 1'b1;
    end else if (priority_sel == kmpc_pkg::MODE_NORMAL) begin
      allowed   = (state_i.mode != kmpc_pkg::MODE_NORMAL);
      threshold = cfg_i.return_ticks;
    end else if (priority_sel > state_i.mode) begin
      // Move mode does not yield to sos.
      allowed = !(state_i.mode == kmpc_pkg::MODE_MOVE && priority_sel == kmpc_pkg::MODE_SOS);
    end
  end

  assign press_fire  = state_i.press_count > cfg_i.long_press_ticks;
  assign settle_fire = state_i.settle_count > threshold;

  always_comb begin
    state_o  = state_i;
    events_o = '0;
    if (!keys_i.action) begin
      if (!keys_i.power_key) begin
        state_o.press_count = '0;
        state_o.key_locked  = 1'b0;
      end else if (!state_i.power_on && !state_i.key_locked) begin
        if (state_i.press_count != kmpc_pkg::PRESS_MAX) begin
          state_o.press_count = state_i.press_count + 16'd1;
        end
        if (press_fire) begin
          state_o.key_locked    = 1'b1;
          state_o.press_count   = '0;
          state_o.power_on      = 1'b1;
          state_o.mode          = kmpc_pkg::MODE_NONE;
          state_o.settle_count  = '0;
          state_o.last_priority = kmpc_pkg::MODE_NONE;
          events_o.power_started = 1'b1;
        end
      end
    end else if (state_i.power_on && state_i.mode <= kmpc_pkg::MODE_PULL) begin
      if (priority_sel != state_i.last_priority) begin
        state_o.last_priority = priority_sel;
        state_o.settle_count  = '0;
      end else if (!allowed) begin
        state_o.settle_count = '0;
      end else begin
        if (state_i.settle_count != kmpc_pkg::SETTLE_MAX) begin
          state_o.settle_count = state_i.settle_count + 8'd1;
        end
        if (settle_fire) begin
          state_o.mode          = priority_sel;
          events_o.mode_started = priority_sel;
        end
      end
    end
  end

endmodule

[tb/tb_key_mode_priority_controller_top.sv]
`timescale 1ns / 100ps

module tb_key_mode_priority_controller_top;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic       powered;
    logic       power_started;
    logic [2:0] mode;
    logic [2:0] mode_started;
    logic       alarm_led;
  } ctrl_status_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    kmpc_pkg::keys_t keys;
    int              reps;
    bit              typed;
    ctrl_status_t    want;
    logic [1:0]      index;
    logic [15:0]     data;
  } plan_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  kmpc_pkg::keys_t tick_keys;
  logic            out_valid_o;
  logic            out_ready_i;
  logic            powered_o;
  logic            power_started_o;
  logic [2:0]      mode_o;
  logic [2:0]      mode_started_o;
  logic            alarm_led_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i;
  logic [15:0]     cfg_data_i;

  // Predicted controller state and registers.
  logic [15:0]  cfg_long_press = kmpc_pkg::LONG_PRESS_RESET;
  logic [7:0]   cfg_escalate   = kmpc_pkg::ESCALATE_RESET;
  logic [7:0]   cfg_return     = kmpc_pkg::RETURN_RESET;
  logic         st_powered     = 1'b0;
  logic [15:0]  st_press       = '0;
  logic         st_locked      = 1'b0;
  logic [2:0]   st_mode        = kmpc_pkg::MODE_NONE;
  logic [7:0]   st_settle      = '0;
  logic [2:0]   st_last_pri    = kmpc_pkg::MODE_NONE;

  ctrl_status_t status_due[$];
  plan_row_t    plan[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int ready_hold = 0;
  int errors = 0;
  int n_ticks = 0;
  int n_checked = 0;
  int n_latches = 0;
  int entered[8];

  key_mode_priority_controller_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (tick_keys.action),
    .power_key_i     (tick_keys.power_key),
    .sos_key_i       (tick_keys.sos_key),
    .move_key_i      (tick_keys.move_key),
    .pull_key_i      (tick_keys.pull_key),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .powered_o       (powered_o),
    .power_started_o (power_started_o),
    .mode_o          (mode_o),
    .mode_started_o  (mode_started_o),
    .alarm_led_o     (alarm_led_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d results still outstanding", status_due.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic kmpc_pkg::keys_t keys(int a, int p, int s, int m, int l);
    kmpc_pkg::keys_t k;
    k.action = 1'(a);
    k.power_key = 1'(p);
    k.sos_key = 1'(s);
    k.move_key = 1'(m);
    k.pull_key = 1'(l);
    return k;
  endfunction

  function automatic ctrl_status_t status(int p, int ps, logic [2:0] m, logic [2:0] ms, int a);
    ctrl_status_t r;
    r.powered = 1'(p);
    r.power_started = 1'(ps);
    r.mode = m;
    r.mode_started = ms;
    r.alarm_led = 1'(a);
    return r;
  endfunction

  // Slow tick whose key levels resolve to the given priority; the lower keys
  // are random where a higher one masks them.
  function automatic kmpc_pkg::keys_t slow_keys_for(logic [2:0] pri);
    kmpc_pkg::keys_t k;
    k = 5'($urandom_range(0, 31));
    k.action = 1'b1;
    case (pri)
      kmpc_pkg::MODE_PULL: k.pull_key = 1'b1;
      kmpc_pkg::MODE_MOVE: begin
        k.pull_key = 1'b0;
        k.move_key = 1'b1;
      end
      kmpc_pkg::MODE_SOS: begin
        k.pull_key = 1'b0;
        k.move_key = 1'b0;
        k.sos_key = 1'b1;
      end
      default: begin
        k.pull_key = 1'b0;
        k.move_key = 1'b0;
        k.sos_key = 1'b0;
      end
    endcase
    return k;
  endfunction

  task automatic advance_controller(input kmpc_pkg::keys_t k, output ctrl_status_t r);
    logic [2:0] pri;
    logic [7:0] thr;
    logic       allowed;
    logic       fire;
    r = '0;
    if (!k.action) begin
      if (!k.power_key) begin
        st_press = '0;
        st_locked = 1'b0;
      end else if (!st_powered && !st_locked) begin
        fire = st_press > cfg_long_press;
        if (st_press != kmpc_pkg::PRESS_MAX) st_press++;
        if (fire) begin
          st_locked = 1'b1;
          st_press = '0;
          st_powered = 1'b1;
          st_mode = kmpc_pkg::MODE_NONE;
          st_settle = '0;
          st_last_pri = kmpc_pkg::MODE_NONE;
          r.power_started = 1'b1;
        end
      end
    end else if (st_powered && st_mode <= kmpc_pkg::MODE_PULL) begin
      pri = k.pull_key ? kmpc_pkg::MODE_PULL : k.move_key ? kmpc_pkg::MODE_MOVE :
            k.sos_key ? kmpc_pkg::MODE_SOS : kmpc_pkg::MODE_NORMAL;
      if (pri != st_last_pri) begin
        st_last_pri = pri;
        st_settle = '0;
      end else begin
        thr = cfg_escalate;
        if (st_mode == kmpc_pkg::MODE_NONE) begin
          allowed = 1'b1;
        end else if (pri == kmpc_pkg::MODE_NORMAL) begin
          allowed = st_mode != kmpc_pkg::MODE_NORMAL;
          thr = cfg_return;
        end else begin
          // Move does not yield to sos; pull yields only to normal.
          allowed = pri > st_mode &&
                    !(st_mode == kmpc_pkg::MODE_MOVE && pri == kmpc_pkg::MODE_SOS);
        end
        if (!allowed) begin
          st_settle = '0;
        end else begin
          fire = st_settle > thr;
          if (st_settle != kmpc_pkg::SETTLE_MAX) st_settle++;
          if (fire) begin
            st_mode = pri;
            r.mode_started = pri;
          end
        end
      end
    end
    r.powered = st_powered;
    r.mode = st_mode;
    r.alarm_led = st_mode == kmpc_pkg::MODE_SOS || st_mode == kmpc_pkg::MODE_PULL;
  endtask

  task automatic report_mismatch(string what, logic [2:0] got, logic [2:0] want);
    errors++;
    $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input kmpc_pkg::keys_t k, input bit typed, input ctrl_status_t want);
    int gap;
    ctrl_status_t predicted;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    tick_keys = k;
    do @(posedge clk_i); while (!in_ready_o);
    advance_controller(k, predicted);
    if (!typed) want = predicted;
    status_due.push_back(want);
    n_ticks++;
    if (predicted.power_started) n_latches++;
    entered[predicted.mode_started]++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [15:0] data);
    drain_results();
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      kmpc_pkg::CFG_LONG_PRESS: cfg_long_press = data;
      kmpc_pkg::CFG_ESCALATE:   cfg_escalate = data[7:0];
      kmpc_pkg::CFG_RETURN:     cfg_return = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_tick(input kmpc_pkg::keys_t k, input int reps);
    plan_row_t row;
    row = '{kind: ROW_TICK, keys: k, reps: reps, typed: 1'b0, want: '0, index: '0, data: '0};
    plan.push_back(row);
  endtask

  task automatic add_checked(input kmpc_pkg::keys_t k, input ctrl_status_t want);
    plan_row_t row;
    row = '{kind: ROW_TICK, keys: k, reps: 1, typed: 1'b1, want: want, index: '0, data: '0};
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [1:0] index, input logic [15:0] data);
    plan_row_t row;
    row = '{kind: ROW_CFG, keys: '0, reps: 0, typed: 1'b0, want: '0, index: index, data: data};
    plan.push_back(row);
  endtask

  initial begin : result_sink
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (ready_hold > 0) begin
        out_ready_i = 1'b0;
        repeat (ready_hold) @(negedge clk_i);
        ready_hold = 0;
      end
      gap = rx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_results
    ctrl_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with nothing pending", mode_o, kmpc_pkg::MODE_NONE);
      end else begin
        want = status_due.pop_front();
        n_checked++;
        if (powered_o !== want.powered)
          report_mismatch("powered", 3'(powered_o), 3'(want.powered));
        if (power_started_o !== want.power_started)
          report_mismatch("power_started", 3'(power_started_o), 3'(want.power_started));
        if (mode_o !== want.mode)
          report_mismatch("mode", mode_o, want.mode);
        if (mode_started_o !== want.mode_started)
          report_mismatch("mode_started", mode_started_o, want.mode_started);
        if (alarm_led_o !== want.alarm_led)
          report_mismatch("alarm_led", 3'(alarm_led_o), 3'(want.alarm_led));
      end
    end
  end

  initial begin : stimulus
    logic [2:0]      pri;
    logic [7:0]      esc;
    logic [7:0]      ret;
    kmpc_pkg::keys_t k;
    int              sent;
    int              len;
    int              pick;
    bit              paused;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    tick_keys = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = kmpc_pkg::CFG_LONG_PRESS;
    cfg_data_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Power off: slow ticks, a short press and released keys leave everything at reset.
    add_checked(keys(1, 1, 1, 1, 1), status(0, 0, kmpc_pkg::MODE_NONE, kmpc_pkg::MODE_NONE, 0));
    add_checked(keys(0, 0, 1, 1, 1), status(0, 0, kmpc_pkg::MODE_NONE, kmpc_pkg::MODE_NONE, 0));
    add_tick(keys(0, 1, 0, 0, 0), 5);
    add_checked(keys(0, 0, 0, 0, 0), status(0, 0, kmpc_pkg::MODE_NONE, kmpc_pkg::MODE_NONE, 0));
    // The largest threshold holds the power off; a lower one latches on the
    // next held tick once the count already exceeds it.
    add_cfg(kmpc_pkg::CFG_LONG_PRESS, 16'hFFFF);
    add_tick(keys(0, 1, 0, 0, 0), 40);
    add_cfg(kmpc_pkg::CFG_LONG_PRESS, 16'd39);
    add_checked(keys(0, 1, 0, 0, 0), status(1, 1, kmpc_pkg::MODE_NONE, kmpc_pkg::MODE_NONE, 0));
    add_checked(keys(0, 1, 1, 1, 1), status(1, 0, kmpc_pkg::MODE_NONE, kmpc_pkg::MODE_NONE, 0));
    add_checked(keys(0, 0, 0, 0, 0), status(1, 0, kmpc_pkg::MODE_NONE, kmpc_pkg::MODE_NONE, 0));
    add_cfg(kmpc_pkg::CFG_ESCALATE, 16'h0000);
    add_cfg(kmpc_pkg::CFG_RETURN, 16'h0001);
    // Walk the mode ladder, try the transitions that are refused and return to normal.
    add_tick(keys(1, 0, 0, 0, 0), 3);
    add_tick(keys(1, 0, 1, 0, 0), 3);
    add_tick(keys(1, 1, 1, 1, 0), 3);
    add_tick(keys(1, 0, 1, 0, 0), 2);
    add_tick(keys(1, 0, 0, 0, 1), 3);
    add_tick(keys(1, 0, 0, 1, 0), 2);
    add_tick(keys(1, 0, 0, 0, 0), 4);
    add_checked(keys(0, 1, 1, 1, 1), status(1, 0, kmpc_pkg::MODE_NORMAL, kmpc_pkg::MODE_NONE, 0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        cfg_write(plan[i].index, plan[i].data);
      end else begin
        repeat (plan[i].reps) send_tick(plan[i].keys, plan[i].typed, plan[i].want);
      end
    end

    paused = 1'b0;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin esc = 8'd0;   ret = 8'd0;   end
        1: begin esc = 8'd255; ret = 8'd255; end
        2: begin esc = 8'd254; ret = 8'd254; end
        3: begin esc = 8'd1;   ret = 8'd255; end
        default: begin
          esc = 8'($urandom_range(0, 6));
          ret = 8'($urandom_range(0, 6));
        end
      endcase
      cfg_write(kmpc_pkg::CFG_LONG_PRESS, 16'($urandom_range(0, 65535)));
      cfg_write(kmpc_pkg::CFG_ESCALATE, {8'($urandom_range(0, 255)), esc});
      cfg_write(kmpc_pkg::CFG_RETURN, {8'($urandom_range(0, 255)), ret});
      if (ph == 5) cfg_write(CFG_UNUSED, 16'($urandom_range(0, 65535)));
      tx_idle = (ph % 3) != 2;
      rx_idle = (ph % 4) != 3;
      if (ph == 4) begin
        // Back-to-back ticks against a stalled receiver fill the block.
        tx_idle = 1'b0;
        ready_hold = 40;
      end
      if (esc >= 8'd200) begin
        // A steady allowed priority long enough to saturate the settle counter.
        pri = (st_mode != kmpc_pkg::MODE_PULL) ? kmpc_pkg::MODE_PULL : kmpc_pkg::MODE_NORMAL;
        repeat (270) send_tick(slow_keys_for(pri), 1'b0, '0);
      end
      sent = 0;
      while (sent < 80) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          pri = 3'($urandom_range(kmpc_pkg::MODE_NORMAL, kmpc_pkg::MODE_PULL));
          len = $urandom_range(1, 12);
          repeat (len) send_tick(slow_keys_for(pri), 1'b0, '0);
          sent += len;
        end else begin
          k = 5'($urandom_range(0, 31));
          k.action = pick == 9;
          send_tick(k, 1'b0, '0);
          sent++;
        end
        if (ph == 6 && sent >= 50 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (5) @(negedge clk_i);
    $display("Checked %0d of %0d ticks; power latched %0d time(s) after a long press.",
             n_checked, n_ticks, n_latches);
    $display("Mode entries normal/sos/move/pull: %0d/%0d/%0d/%0d; thresholds 0 to 255.",
             entered[kmpc_pkg::MODE_NORMAL], entered[kmpc_pkg::MODE_SOS],
             entered[kmpc_pkg::MODE_MOVE], entered[kmpc_pkg::MODE_PULL]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
